// ===== design/modbus_read_reply_parser_macros.svh =====
// assertion macros for the modbus read reply parser
`ifndef MODBUS_READ_REPLY_PARSER_MACROS_SVH
`define MODBUS_READ_REPLY_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MBRP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MBRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mbrp_pkg.sv =====
// shared types, codes and constants of the modbus read reply parser
package mbrp_pkg;

    localparam int MAX_FRAME_DEFAULT = 256;
    localparam int POS_W             = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
    localparam logic [6:0]  TEMP_SCALE = 7'd100;

    // result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_SIZE     = 3'd1;
    localparam logic [2:0] STAT_ADDRESS  = 3'd2;
    localparam logic [2:0] STAT_FUNCTION = 3'd3;
    localparam logic [2:0] STAT_COUNT    = 3'd4;
    localparam logic [2:0] STAT_CRC      = 3'd5;

    // header error codes
    localparam logic [1:0] HDR_NONE     = 2'd0;
    localparam logic [1:0] HDR_ADDRESS  = 2'd1;
    localparam logic [1:0] HDR_FUNCTION = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_SLAVE_ADDRESS = 3'd0;
    localparam logic [2:0] CFG_FUNCTION_CODE = 3'd1;
    localparam logic [2:0] CFG_VOLT_FLAG_IDX = 3'd2;
    localparam logic [2:0] CFG_TEMP_FLAG_IDX = 3'd3;
    localparam logic [2:0] CFG_TEMP_IDX      = 3'd4;

    // per-result side information travelling with the temperature pipeline
    typedef struct packed {
        logic [2:0] status;
        logic [3:0] channel;
        logic       volt_set;
        logic       tflag_set;
    } mbrp_meta_t;

endpackage

// ===== design/mbrp_temp_scale.sv =====
// two-stage float32 times 100 to truncated int32 converter
module mbrp_temp_scale (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] bits_in,
    output logic [31:0] value_out
);

    localparam logic [6:0] TEMP_SCALE_W = mbrp_pkg::TEMP_SCALE;

    // stage one: mantissa product
    logic        s1_sign_reg;
    logic [7:0]  s1_exp_reg;
    logic        s1_nan_reg;
    logic [30:0] s1_prod_reg;
    logic [23:0] mant;

    assign mant = {1'b1, bits_in[22:0]};

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_sign_reg <= bits_in[31];
            s1_exp_reg  <= bits_in[30:23];
            s1_nan_reg  <= (bits_in[22:0] != 23'd0);
            s1_prod_reg <= 31'({7'd0, mant} * {24'd0, TEMP_SCALE_W});
        end
    end

    // stage two: round to single precision, shift, saturate
    logic [24:0] rnd;
    logic [31:0] prod_rnd;
    logic signed [9:0] sh;
    logic [9:0]  nsh;
    logic [32:0] mag;
    logic        sat;
    logic        zero;
    logic [31:0] value_next;
    logic [31:0] value_reg;

    always_comb begin
        if (s1_prod_reg[30]) begin
            rnd = {1'b0, s1_prod_reg[30:7]} + 25'(s1_prod_reg[6] &
                  ((|s1_prod_reg[5:0]) | s1_prod_reg[7]));
            prod_rnd = {rnd, 7'd0};
        end else begin
            rnd = {1'b0, s1_prod_reg[29:6]} + 25'(s1_prod_reg[5] &
                  ((|s1_prod_reg[4:0]) | s1_prod_reg[6]));
            prod_rnd = {1'b0, rnd, 6'd0};
        end
        sh   = $signed({2'b00, s1_exp_reg}) - 10'sd150;
        nsh  = 10'(-sh);
        mag  = 33'd0;
        sat  = 1'b0;
        zero = 1'b0;
        if (s1_exp_reg == 8'hFF) begin
            zero = s1_nan_reg;
            sat  = !s1_nan_reg;
        end else if (s1_exp_reg == 8'd0) begin
            zero = 1'b1;
        end else if (sh >= 10'sd2) begin
            sat = 1'b1;
        end else if (sh == 10'sd1) begin
            mag = {prod_rnd, 1'b0};
        end else if (sh == 10'sd0) begin
            mag = {1'b0, prod_rnd};
        end else if (nsh >= 10'd32) begin
            zero = 1'b1;
        end else begin
            mag = {1'b0, prod_rnd >> nsh[4:0]};
        end
        if (mag[32:31] != 2'b00) begin
            sat = 1'b1;
        end
        if (zero) begin
            value_next = 32'd0;
        end else if (sat) begin
            value_next = s1_sign_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (s1_sign_reg) begin
            value_next = 32'(-mag[31:0]);
        end else begin
            value_next = mag[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign value_out = value_reg;

endmodule

// ===== design/modbus_read_reply_parser.sv =====
// top level of the modbus read reply parser
// Parses Modbus RTU "read input registers" replies one byte per transaction and gives one
// result per frame on the byte flagged frame_end. A byte is taken every cycle unless the pipeline stalls; a result
// passes from the input register through the frame stage, float product stage and rounding
// stage, and the pipeline stalls only while the result waits. Flags and temperature are zero
// unless the status is ok.
`include "modbus_read_reply_parser_macros.svh"

module modbus_read_reply_parser #(
    parameter int MAX_FRAME = mbrp_pkg::MAX_FRAME_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,
    input  logic [3:0]  s_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_channel_out,
    output logic        m_voltage_flag,
    output logic        m_temp_flag,
    output logic signed [31:0] m_temperature
);

    localparam int POS_W = mbrp_pkg::POS_W;
    localparam logic [POS_W-1:0] LEN_MAX = POS_W'(MAX_FRAME - 1);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // configuration registers
    logic [7:0] slave_address_reg;
    logic [7:0] function_code_reg;
    logic [6:0] volt_idx_reg;
    logic [6:0] temp_flag_idx_reg;
    logic [6:0] temp_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= 8'd1;
            function_code_reg <= 8'd4;
            volt_idx_reg      <= 7'd0;
            temp_flag_idx_reg <= 7'd1;
            temp_idx_reg      <= 7'd2;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mbrp_pkg::CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_wr_data;
                mbrp_pkg::CFG_FUNCTION_CODE: function_code_reg <= cfg_wr_data;
                mbrp_pkg::CFG_VOLT_FLAG_IDX: volt_idx_reg      <= cfg_wr_data[6:0];
                mbrp_pkg::CFG_TEMP_FLAG_IDX: temp_flag_idx_reg <= cfg_wr_data[6:0];
                mbrp_pkg::CFG_TEMP_IDX:      temp_idx_reg      <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // input register
    logic       a_valid_reg;
    logic [7:0] a_byte_reg;
    logic       a_end_reg;
    logic [3:0] a_ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
        end
        if (en) begin
            a_byte_reg <= s_rx_byte;
            a_end_reg  <= s_frame_end;
            a_ch_reg   <= s_channel;
        end
    end

    // per-frame state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  count_reg, count_next;
    logic [1:0]  hdr_reg, hdr_next;
    logic [7:0]  pend_reg, pend_next;
    logic        vseen_reg, vseen_next;
    logic        tseen_reg, tseen_next;
    logic [15:0] thigh_reg, thigh_next;
    logic [31:0] tbits_reg, tbits_next;
    logic        tvalid_reg, tvalid_next;

    logic [POS_W-1:0] off;
    logic [15:0] word;
    logic [POS_W-2:0] ridx;
    logic [2:0]  status;
    logic [8:0]  expect_len;
    logic        frame_ok;
    mbrp_pkg::mbrp_meta_t b_meta_next;
    logic [31:0] b_bits_next;

    always_comb begin
        pos_next    = pos_reg;
        count_next  = count_reg;
        hdr_next    = hdr_reg;
        pend_next   = pend_reg;
        vseen_next  = vseen_reg;
        tseen_next  = tseen_reg;
        thigh_next  = thigh_reg;
        tbits_next  = tbits_reg;
        tvalid_next = tvalid_reg;

        // crc over this byte, one shift per bit
        crc_next = crc_reg ^ {8'd0, a_byte_reg};
        for (int k = 0; k < 8; k++) begin
            if (crc_next[0]) begin
                crc_next = (crc_next >> 1) ^ mbrp_pkg::CRC_POLY;
            end else begin
                crc_next = crc_next >> 1;
            end
        end

        // header checks
        if (pos_reg == POS_W'(0) && a_byte_reg != slave_address_reg) begin
            hdr_next = mbrp_pkg::HDR_ADDRESS;
        end
        if (pos_reg == POS_W'(1) && hdr_reg == mbrp_pkg::HDR_NONE &&
            a_byte_reg != function_code_reg) begin
            hdr_next = mbrp_pkg::HDR_FUNCTION;
        end
        if (pos_reg == POS_W'(2)) begin
            count_next = a_byte_reg;
        end

        // register extraction inside the declared data region
        off  = pos_reg - POS_W'(3);
        word = {pend_reg, a_byte_reg};
        ridx = off[POS_W-1:1];
        if (pos_reg >= POS_W'(3) && off < POS_W'(count_reg)) begin
            if (!off[0]) begin
                pend_next = a_byte_reg;
            end else if (ridx == (POS_W-1)'(volt_idx_reg)) begin
                vseen_next = (word != 16'd0);
            end else if (ridx == (POS_W-1)'(temp_flag_idx_reg)) begin
                tseen_next = (word != 16'd0);
            end else if (ridx == (POS_W-1)'(temp_idx_reg)) begin
                thigh_next = word;
            end else if (ridx == (POS_W-1)'({1'b0, temp_idx_reg} + 8'd1)) begin
                tbits_next  = {thigh_reg, word};
                tvalid_next = 1'b1;
            end
        end

        pos_next = (pos_reg < mbrp_pkg::POS_MAX) ? pos_reg + POS_W'(1) : mbrp_pkg::POS_MAX;

        // frame status, first failing check wins
        expect_len = mbrp_pkg::FRAME_OVERHEAD + {1'b0, count_next};
        if (pos_next < POS_W'(5) || pos_next > LEN_MAX) begin
            status = mbrp_pkg::STAT_SIZE;
        end else if (hdr_next == mbrp_pkg::HDR_ADDRESS) begin
            status = mbrp_pkg::STAT_ADDRESS;
        end else if (hdr_next == mbrp_pkg::HDR_FUNCTION) begin
            status = mbrp_pkg::STAT_FUNCTION;
        end else if (pos_next != POS_W'(expect_len)) begin
            status = mbrp_pkg::STAT_COUNT;
        end else if (crc_next != 16'd0) begin
            status = mbrp_pkg::STAT_CRC;
        end else begin
            status = mbrp_pkg::STAT_OK;
        end
        frame_ok = (status == mbrp_pkg::STAT_OK);

        b_meta_next.status    = status;
        b_meta_next.channel   = a_ch_reg;
        b_meta_next.volt_set  = frame_ok & vseen_next;
        b_meta_next.tflag_set = frame_ok & tseen_next;
        b_bits_next = (frame_ok && tvalid_next) ? tbits_next : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            crc_reg    <= mbrp_pkg::CRC_INIT;
            count_reg  <= 8'd0;
            hdr_reg    <= mbrp_pkg::HDR_NONE;
            pend_reg   <= 8'd0;
            vseen_reg  <= 1'b0;
            tseen_reg  <= 1'b0;
            thigh_reg  <= 16'd0;
            tbits_reg  <= 32'd0;
            tvalid_reg <= 1'b0;
        end else if (en && a_valid_reg) begin
            if (a_end_reg) begin
                pos_reg    <= '0;
                crc_reg    <= mbrp_pkg::CRC_INIT;
                count_reg  <= 8'd0;
                hdr_reg    <= mbrp_pkg::HDR_NONE;
                pend_reg   <= 8'd0;
                vseen_reg  <= 1'b0;
                tseen_reg  <= 1'b0;
                thigh_reg  <= 16'd0;
                tbits_reg  <= 32'd0;
                tvalid_reg <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                crc_reg    <= crc_next;
                count_reg  <= count_next;
                hdr_reg    <= hdr_next;
                pend_reg   <= pend_next;
                vseen_reg  <= vseen_next;
                tseen_reg  <= tseen_next;
                thigh_reg  <= thigh_next;
                tbits_reg  <= tbits_next;
                tvalid_reg <= tvalid_next;
            end
        end
    end

    // result pipeline: frame stage, product stage, output stage
    logic b_valid_reg, c_valid_reg, d_valid_reg;
    mbrp_pkg::mbrp_meta_t b_meta_reg, c_meta_reg, d_meta_reg;
    logic [31:0] b_bits_reg;
    logic [31:0] temp_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg && a_end_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
        if (en) begin
            b_meta_reg <= b_meta_next;
            b_bits_reg <= b_bits_next;
            c_meta_reg <= b_meta_reg;
            d_meta_reg <= c_meta_reg;
        end
    end

    mbrp_temp_scale u_temp_scale (
        .aclk      (aclk),
        .en        (en),
        .bits_in   (b_bits_reg),
        .value_out (temp_value)
    );

    assign m_valid        = d_valid_reg;
    assign m_status       = d_meta_reg.status;
    assign m_channel_out  = d_meta_reg.channel;
    assign m_voltage_flag = d_meta_reg.volt_set;
    assign m_temp_flag    = d_meta_reg.tflag_set;
    assign m_temperature  = $signed(temp_value);

    // checks
    logic fail_out;
    logic fail_data;
    logic out_stall;
    logic end_taken;
    logic state_clear;

    assign fail_out    = m_valid && m_status != mbrp_pkg::STAT_OK;
    assign fail_data   = m_voltage_flag || m_temp_flag || m_temperature != 32'sd0;
    assign out_stall   = m_valid && !m_ready;
    assign end_taken   = en && a_valid_reg && a_end_reg;
    assign state_clear = pos_reg == '0 && crc_reg == mbrp_pkg::CRC_INIT;

    `MBRP_ASSERT_NOW(a_fail_clears, aclk, aresetn, fail_out, !fail_data, "failed frame data")
    `MBRP_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, out_stall, "stall without result")
    `MBRP_ASSERT_NEXT(a_frame_restart, aclk, aresetn, end_taken, state_clear, "frame not cleared")

endmodule
